// ===== hw/rtl/rcd_pkg.sv =====
// Shared types, constants and helper functions for the radix-to-digits block.
// Depends on nothing; rcd_div and the core import it, rcd_ram does not.
package rcd_pkg;

	localparam int VALUE_W           = 31;
	localparam int RADIX_W           = 6;
	localparam int DIGIT_W           = 6;
	localparam int CHAR_W            = 7;
	localparam int IN_TDATA_W        = 32;
	localparam int OUT_TDATA_W       = 8;

	localparam int DIGIT_STORE_DEPTH = 32;
	localparam int STORE_AW          = $clog2(DIGIT_STORE_DEPTH);
	localparam int COUNT_W           = $clog2(DIGIT_STORE_DEPTH + 1);

	// Divider: dividend padded to DIV_W, DIV_STEP bits retired per cycle
	localparam int DIV_W             = 32;
	localparam int DIV_STEP          = 4;
	localparam int DIV_CYCLES        = DIV_W / DIV_STEP;
	localparam int DIV_CNT_W         = $clog2(DIV_CYCLES);

	localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
	localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);

	localparam logic [CHAR_W-1:0]  ASCII_ZERO  = CHAR_W'(48);
	localparam logic [CHAR_W-1:0]  ASCII_A     = CHAR_W'(65);
	localparam logic [DIGIT_W-1:0] DEC_MAX     = DIGIT_W'(9);
	localparam logic [CHAR_W-1:0]  DEC_BASE    = CHAR_W'(10);

	typedef struct packed {
		logic                done;
		logic [VALUE_W-1:0]  quotient;
		logic [DIGIT_W-1:0]  remainder;
	} rcd_div_status_t;

	function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
		logic [RADIX_W-1:0] res;
		res = r;
		if (r < RADIX_MIN) begin
			res = RADIX_MIN;
		end else if (r > RADIX_MAX) begin
			res = RADIX_MAX;
		end
		return res;
	endfunction

	function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d > DEC_MAX) begin
			c = CHAR_W'(d) + (ASCII_A - DEC_BASE);
		end else begin
			c = CHAR_W'(d) + ASCII_ZERO;
		end
		return c;
	endfunction

endpackage

// ===== hw/rtl/rcd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module rcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/rcd_div.sv =====
// Iterative restoring divider: value by radix, DIV_STEP quotient bits per cycle.
// Depends on rcd_pkg.
module rcd_div
	import rcd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [VALUE_W-1:0]  dividend,
	input  logic [RADIX_W-1:0]  divisor,
	output rcd_div_status_t     status
);

	logic [DIV_W-1:0]     quo_q;
	logic [DIGIT_W-1:0]   rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [DIV_W-1:0]     quo_nxt;
	logic [DIGIT_W-1:0]   rem_nxt;

	// Retire DIV_STEP quotient bits: shift in the next dividend bit, subtract if it fits
	always_comb begin
		logic [DIGIT_W:0] trial;
		quo_nxt = quo_q;
		rem_nxt = rem_q;
		for (int i = 0; i < DIV_STEP; i++) begin
			trial   = {rem_nxt, quo_nxt[DIV_W-1]};
			quo_nxt = {quo_nxt[DIV_W-2:0], 1'b0};
			if (trial >= {1'b0, divisor}) begin
				rem_nxt    = DIGIT_W'(trial - {1'b0, divisor});
				quo_nxt[0] = 1'b1;
			end else begin
				rem_nxt = DIGIT_W'(trial);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_CYCLES - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= DIV_W'(dividend);
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= quo_nxt;
			rem_q <= rem_nxt;
		end
	end

	assign status.done      = done_q;
	assign status.quotient  = quo_q[VALUE_W-1:0];
	assign status.remainder = rem_q;

endmodule

// ===== hw/rtl/radix_conversion_to_digits_core.sv =====
// Top level of the radix-to-ASCII-digits converter: sequencer, digit store, output register.
// Depends on rcd_pkg, rcd_div and rcd_ram.
//
//  Channel | Direction | Signals                          | Payload
//  --------+-----------+----------------------------------+----------------------------------
//  s       | in        | s_tvalid s_tready s_tdata        | value (31 bit unsigned)
//  m       | out       | m_tvalid m_tready m_tdata m_tlast| digit_char (7 bit ASCII), last_digit
//  cfg     | in        | cfg_valid cfg_ready cfg_data     | radix (6 bit, clamped to 2..36)
//
// Each digit takes one pass of the shared divider, whose done pulse stores the remainder and
// restarts it on the quotient; once the quotient is zero the D digits are read back from the
// store, most significant first (D is 1..31).
// The divider's 4-bit-per-cycle restoring loop sets the division time.
// Reset clears the sequencer, counter, radix (to 10) and output valid; the digit store has
// no reset and needs no clearing pass. s_tready is high only when the sequencer is idle;
// a stalled m_tready holds the current digit in the output register and freezes the readout.
module radix_conversion_to_digits_core
	import rcd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,

	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // [30:0] value, [31] zero

	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // [6:0] digit_char, [7] zero
	output logic                   m_tlast,   // last_digit

	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [RADIX_W-1:0]     cfg_data   // radix
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DIV  = 2'd1;
	localparam logic [1:0] S_RD   = 2'd2;
	localparam logic [1:0] S_LD   = 2'd3;

	logic [1:0]          state_q;
	logic [RADIX_W-1:0]  radix_q;
	logic [COUNT_W-1:0]  count_q;

	logic                m_valid_q;
	logic [CHAR_W-1:0]   m_char_q;
	logic                m_last_q;

	logic                s_xfer;
	logic                div_start;
	logic [VALUE_W-1:0]  div_dividend;
	rcd_div_status_t     div_st;

	logic                st_we;
	logic [STORE_AW-1:0] st_raddr;
	logic [DIGIT_W-1:0]  st_rdata;
	logic                out_free;

	assign s_tready  = (state_q == S_IDLE);
	assign s_xfer    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign out_free  = !m_valid_q || m_tready;

	// Start a division on a new transaction, and again after each digit while quotient is nonzero.
	// A zero input runs one pass too and yields the single digit zero.
	assign div_start    = s_xfer ||
	                      (state_q == S_DIV && div_st.done && div_st.quotient != '0);
	assign div_dividend = s_xfer ? s_tdata[VALUE_W-1:0] : div_st.quotient;

	// Store the remainder unless the store is full
	assign st_we    = (state_q == S_DIV) && div_st.done &&
	                  (count_q < COUNT_W'(DIGIT_STORE_DEPTH));
	// Outside the read state, keep addressing the entry being loaded so a stall holds it
	assign st_raddr = (state_q == S_RD) ? STORE_AW'(count_q - 1'b1) : count_q[STORE_AW-1:0];

	rcd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (eff_radix(radix_q)),
		.status   (div_st)
	);

	rcd_ram #(
		.WIDTH (DIGIT_W),
		.DEPTH (DIGIT_STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (count_q[STORE_AW-1:0]),
		.wdata (div_st.remainder),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			radix_q   <= RADIX_RESET;
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				radix_q <= cfg_data;
			end
			// Load a new digit, or drop valid once the held digit is taken
			if (state_q == S_LD && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_xfer) begin
						count_q <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_st.done) begin
						if (st_we) begin
							count_q <= count_q + 1'b1;
						end
						if (div_st.quotient == '0) begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					// read address issued this cycle; drop the count to the entry being read
					count_q <= count_q - 1'b1;
					state_q <= S_LD;
				end
				S_LD: begin
					if (out_free) begin
						state_q <= (count_q == '0) ? S_IDLE : S_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Output payload: load when the digit is handed to the output register
	always_ff @(posedge clk) begin
		if (state_q == S_LD && out_free) begin
			m_char_q <= digit_to_ascii(st_rdata);
			m_last_q <= (count_q == '0);
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = OUT_TDATA_W'(m_char_q);
	assign m_tlast  = m_last_q;

endmodule
